### hw/rtl/blg_pkg.sv
// Shared types and fixed widths for the Bresenham line generator.
// No dependencies; every module of the block imports this package.
package blg_pkg;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } blg_op_t;

  localparam int COLOR_BITS  = 32;
  localparam int STEP_BITS   = 2;
  localparam int ERR_EXTRA   = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic valid;
    logic full;
  } blg_qstat_t;

endpackage

### hw/rtl/blg_front.sv
// Front end of the line generator: passes each input word's operation on and works out
// the line setup (steps, major axis, extents, initial error) for a load.
// Depends on blg_pkg.
module blg_front import blg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  operation,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_BITS-1:0] color,
  output logic [5*COORD_BITS+ERR_EXTRA+2*STEP_BITS+COLOR_BITS+1:0] entry
);

  localparam int CB = COORD_BITS;

  logic [CB:0]               dx;
  logic [CB:0]               dy;
  logic [CB-1:0]             adx;
  logic [CB-1:0]             ady;
  logic [STEP_BITS-1:0]      stx;
  logic [STEP_BITS-1:0]      sty;
  logic                      ymaj;
  logic [CB-1:0]             major;
  logic [CB-1:0]             minor;
  logic signed [CB+ERR_EXTRA-1:0] err;

  always_comb begin
    dx   = {1'b0, x_end} - {1'b0, x_start};
    dy   = {1'b0, y_end} - {1'b0, y_start};
    adx  = dx[CB] ? (x_start - x_end) : dx[CB-1:0];
    ady  = dy[CB] ? (y_start - y_end) : dy[CB-1:0];
    stx  = (dx == '0) ? 2'b00 : (dx[CB] ? 2'b11 : 2'b01);
    sty  = (dy == '0) ? 2'b00 : (dy[CB] ? 2'b11 : 2'b01);
    ymaj = adx < ady;
    major = ymaj ? ady : adx;
    minor = ymaj ? adx : ady;
    err  = signed'({2'b00, minor, 1'b0}) - signed'({3'b000, major});
  end

  assign entry = {operation, x_start, y_start, major, minor, err, stx, sty, ymaj, color};

endmodule

### hw/rtl/blg_queue.sv
// Two-entry queue that decouples the front end from the pixel stepper.
// Depends on blg_pkg.
module blg_queue import blg_pkg::*; #(
  parameter int WIDTH = 90
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output blg_qstat_t       stat
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] slots [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  assign rd_data    = slots[rd_ptr];
  assign stat.valid = count != '0;
  assign stat.full  = count == (PW+1)'(QUEUE_DEPTH);

endmodule

### hw/rtl/blg_back.sv
// Back end of the line generator: holds the line in progress, steps it one
// pixel per tick and drives the output register. Depends on blg_pkg.
module blg_back import blg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  logic [5*COORD_BITS+ERR_EXTRA+2*STEP_BITS+COLOR_BITS+1:0] head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel
);

  localparam int CB = COORD_BITS;
  localparam int EB = CB + ERR_EXTRA;

  logic                  e_op;
  logic [CB-1:0]         e_x;
  logic [CB-1:0]         e_y;
  logic [CB-1:0]         e_major;
  logic [CB-1:0]         e_minor;
  logic signed [EB-1:0]  e_err;
  logic [STEP_BITS-1:0]  e_stx;
  logic [STEP_BITS-1:0]  e_sty;
  logic                  e_ymaj;
  logic [COLOR_BITS-1:0] e_color;

  logic                  active;
  logic [CB-1:0]         cur_x;
  logic [CB-1:0]         cur_y;
  logic [CB:0]           remaining;
  logic signed [EB-1:0]  error_term;
  logic [CB-1:0]         major_delta;
  logic [CB-1:0]         minor_delta;
  logic [STEP_BITS-1:0]  step_x;
  logic [STEP_BITS-1:0]  step_y;
  logic                  y_major;
  logic [COLOR_BITS-1:0] line_color;

  logic                  out_free;
  logic                  is_tick;
  logic                  emit;
  logic                  load;
  logic                  err_ge;
  logic [CB-1:0]         ext_x;
  logic [CB-1:0]         ext_y;
  logic signed [EB-1:0]  error_term_next;
  logic                  is_last;

  assign {e_op, e_x, e_y, e_major, e_minor, e_err, e_stx, e_sty, e_ymaj, e_color} = head;

  always_comb begin
    out_free = !out_valid || !out_stall;
    is_tick  = e_op == OP_TICK;
    load     = head_valid && !is_tick;
    emit     = head_valid && is_tick && active && out_free;
    pop      = load || (head_valid && is_tick && (!active || out_free));
    err_ge   = !error_term[EB-1];
    ext_x    = {{(CB-1){step_x[1]}}, step_x[0]};
    ext_y    = {{(CB-1){step_y[1]}}, step_y[0]};
    error_term_next = error_term + signed'({2'b00, minor_delta, 1'b0})
                    - (err_ge ? signed'({2'b00, major_delta, 1'b0}) : '0);
    is_last  = remaining == {{CB{1'b0}}, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      out_valid  <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      remaining  <= '0;
      error_term <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      step_x     <= '0;
      step_y     <= '0;
      y_major    <= 1'b0;
      line_color <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        active      <= 1'b1;
        cur_x       <= e_x;
        cur_y       <= e_y;
        remaining   <= {1'b0, e_major} + 1'b1;
        error_term  <= e_err;
        major_delta <= e_major;
        minor_delta <= e_minor;
        step_x      <= e_stx;
        step_y      <= e_sty;
        y_major     <= e_ymaj;
        line_color  <= e_color;
      end else if (emit) begin
        if (!y_major || err_ge) begin
          cur_x <= cur_x + ext_x;
        end
        if (y_major || err_ge) begin
          cur_y <= cur_y + ext_y;
        end
        error_term <= error_term_next;
        remaining  <= remaining - 1'b1;
        if (is_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x     <= cur_x;
      pixel_y     <= cur_y;
      pixel_color <= line_color;
      last_pixel  <= is_last;
    end
  end

endmodule

### hw/rtl/bresenham_line_generator_core.sv
// Top level of the Bresenham line generator: front end, queue and stepper.
// Depends on blg_pkg, blg_front, blg_queue and blg_back.
//
//   Channel  Valid      Stall      Payload
//   input    in_valid   in_stall   operation, x_start, y_start, x_end, y_end, color
//   output   out_valid  out_stall  pixel_x, pixel_y, pixel_color, last_pixel
//
// One input word is taken per cycle while in_stall is low; a tick word gives its pixel
// after acceptance by way of the queue and then the output register.
// The stepper retires one word per cycle unless a stalled output holds it, set by its error update and compare.
// Reset clears the queue, drops any line in progress and empties the output.
// A stall on the output holds the stepper, and the queue then fills and stalls the input.
module bresenham_line_generator_core import blg_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  operation,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  input  logic [COLOR_BITS-1:0] color,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic [COLOR_BITS-1:0] pixel_color,
  output logic                  last_pixel
);

  localparam int EW = 5*COORD_BITS + ERR_EXTRA + 2*STEP_BITS + COLOR_BITS + 2;

  logic [EW-1:0] front_entry;
  logic [EW-1:0] head;
  logic          push;
  logic          pop;
  blg_qstat_t    qstat;

  assign in_stall = qstat.full;
  assign push     = in_valid && !in_stall;

  blg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .operation (operation),
    .x_start   (x_start),
    .y_start   (y_start),
    .x_end     (x_end),
    .y_end     (y_end),
    .color     (color),
    .entry     (front_entry)
  );

  blg_queue #(.WIDTH(EW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_entry),
    .pop     (pop),
    .rd_data (head),
    .stat    (qstat)
  );

  blg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (qstat.valid),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (last_pixel)
  );

endmodule

### tb/bresenham_line_generator_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_generator_core with an in-line pixel predictor.
// Depends on blg_pkg and the line generator RTL; needs no files or arguments.
module bresenham_line_generator_core_tb;
  import blg_pkg::*;

  localparam int CB = 12;
  localparam int EW = CB + ERR_EXTRA;
  localparam int CMAX = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int TARGET_WORDS = 1200;

  typedef struct {
    blg_op_t               op;
    logic [CB-1:0]         xs;
    logic [CB-1:0]         ys;
    logic [CB-1:0]         xe;
    logic [CB-1:0]         ye;
    logic [COLOR_BITS-1:0] color;
  } line_word_t;

  typedef struct {
    logic [CB-1:0]         x;
    logic [CB-1:0]         y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = 1'b0;
  logic [CB-1:0]         x_start = '0;
  logic [CB-1:0]         y_start = '0;
  logic [CB-1:0]         x_end = '0;
  logic [CB-1:0]         y_end = '0;
  logic [COLOR_BITS-1:0] color = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CB-1:0]         pixel_x;
  logic [CB-1:0]         pixel_y;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  last_pixel;

  bresenham_line_generator_core #(
    .COORD_BITS(CB)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .x_start(x_start),
    .y_start(y_start),
    .x_end(x_end),
    .y_end(y_end),
    .color(color),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .pixel_color(pixel_color),
    .last_pixel(last_pixel)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  line_word_t pending_words[$];
  pixel_t     expected_pixels[$];

  logic                         ln_active = 1'b0;
  logic [CB-1:0]                ln_x = '0;
  logic [CB-1:0]                ln_y = '0;
  logic [CB:0]                  ln_left = '0;
  logic signed [EW-1:0]         ln_err = '0;
  logic [CB-1:0]                ln_major = '0;
  logic [CB-1:0]                ln_minor = '0;
  logic signed [STEP_BITS-1:0]  ln_step_x = '0;
  logic signed [STEP_BITS-1:0]  ln_step_y = '0;
  logic                         ln_y_major = 1'b0;
  logic [COLOR_BITS-1:0]        ln_color = '0;

  int words_total = 0;
  int useful_words = 0;
  int words_taken = 0;
  int loads_taken = 0;
  int pixels_checked = 0;
  int lines_finished = 0;
  int mismatches = 0;
  int cycle_count = 0;

  line_word_t drv_word;
  logic       in_take;
  int         burst_left = 0;
  int         gap_left = 0;

  int   stall_mode = 0;
  int   stall_run = 0;
  int   stall_clock = 0;
  logic stall_next;

  task automatic apply_word(input line_word_t w);
    int     dx, dy, adx, ady;
    pixel_t px;
    if (w.op == OP_LOAD) begin
      dx = int'(w.xe) - int'(w.xs);
      dy = int'(w.ye) - int'(w.ys);
      ln_step_x = (dx > 0) ? 2'sd1 : ((dx < 0) ? -2'sd1 : 2'sd0);
      ln_step_y = (dy > 0) ? 2'sd1 : ((dy < 0) ? -2'sd1 : 2'sd0);
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      ln_y_major = adx < ady;
      ln_major = CB'(ln_y_major ? ady : adx);
      ln_minor = CB'(ln_y_major ? adx : ady);
      ln_err = EW'(2 * int'(ln_minor) - int'(ln_major));
      ln_left = (CB + 1)'(int'(ln_major) + 1);
      ln_x = w.xs;
      ln_y = w.ys;
      ln_color = w.color;
      ln_active = 1'b1;
    end else if (ln_active) begin
      px.x = ln_x;
      px.y = ln_y;
      px.color = ln_color;
      px.last = (ln_left == 1);
      expected_pixels.push_back(px);
      if (ln_err >= 0) begin
        if (ln_y_major) ln_x = ln_x + CB'(ln_step_x);
        else ln_y = ln_y + CB'(ln_step_y);
        ln_err = EW'(int'(ln_err) - 2 * int'(ln_major));
      end
      if (ln_y_major) ln_y = ln_y + CB'(ln_step_y);
      else ln_x = ln_x + CB'(ln_step_x);
      ln_err = EW'(int'(ln_err) + 2 * int'(ln_minor));
      ln_left = ln_left - 1'b1;
      if (ln_left == 0) ln_active = 1'b0;
    end
  endtask

  function automatic int line_length(input int xs, ys, xe, ye);
    int adx, ady;
    adx = (xe > xs) ? xe - xs : xs - xe;
    ady = (ye > ys) ? ye - ys : ys - ye;
    return ((adx > ady) ? adx : ady) + 1;
  endfunction

  function automatic int near_coord(input int c, input int span);
    int lo, hi;
    lo = (c - span < 0) ? 0 : c - span;
    hi = (c + span > CMAX) ? CMAX : c + span;
    return int'($urandom_range(hi, lo));
  endfunction

  task automatic queue_ticks(input int n);
    line_word_t w;
    for (int i = 0; i < n; i++) begin
      w.op = OP_TICK;
      w.xs = CB'($urandom);
      w.ys = CB'($urandom);
      w.xe = CB'($urandom);
      w.ye = CB'($urandom);
      w.color = $urandom;
      pending_words.push_back(w);
    end
  endtask

  task automatic queue_line(input int xs, ys, xe, ye, input logic [COLOR_BITS-1:0] c,
                            input int ticks);
    line_word_t w;
    int         len;
    len = line_length(xs, ys, xe, ye);
    w.op = OP_LOAD;
    w.xs = CB'(xs);
    w.ys = CB'(ys);
    w.xe = CB'(xe);
    w.ye = CB'(ye);
    w.color = c;
    pending_words.push_back(w);
    queue_ticks(ticks);
    useful_words += 1 + ((ticks < len) ? ticks : len);
  endtask

  task automatic build_stimulus();
    int pick, span, xs, ys, xe, ye, len;
    queue_ticks(1);
    queue_line(5, 5, 5, 5, 32'hFFFF_FFFF, 2);
    queue_line(0, 0, CMAX, CMAX, 32'h0000_0000, 3);
    queue_line(CMAX, CMAX, 0, 0, 32'hA5A5_5A5A, 2);
    queue_line(CMAX - 2, 0, CMAX, 1, 32'h1234_5678, 3);
    queue_line(1, CMAX, 0, CMAX - 1, 32'h8000_0001, 3);
    queue_line(20, 10, 18, 14, 32'h7FFF_FFFE, 5);
    while (useful_words < TARGET_WORDS) begin
      pick = $urandom_range(0, 99);
      xs = $urandom_range(0, CMAX);
      ys = $urandom_range(0, CMAX);
      if (pick < 65) begin
        span = ($urandom_range(0, 19) == 0) ? 150 : 12;
        xe = near_coord(xs, span);
        ye = near_coord(ys, span);
        queue_line(xs, ys, xe, ye, $urandom, line_length(xs, ys, xe, ye));
        if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(1, 2));
      end else if (pick < 80) begin
        queue_line(xs, ys, $urandom_range(0, CMAX), $urandom_range(0, CMAX), $urandom,
                   $urandom_range(0, 30));
      end else if (pick < 88) begin
        queue_line(xs, ys, xs, ys, $urandom, 1);
      end else if (pick < 95) begin
        xe = near_coord(xs, 12);
        ye = near_coord(ys, 12);
        len = line_length(xs, ys, xe, ye);
        queue_line(xs, ys, xe, ye, $urandom, $urandom_range(0, len - 1));
      end else begin
        queue_ticks($urandom_range(1, 3));
      end
    end
    words_total = pending_words.size();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_take = in_valid && !in_stall;
      if (in_take) begin
        apply_word(drv_word);
        if (drv_word.op == OP_LOAD) loads_taken++;
        words_taken++;
      end
      if (!in_valid || in_take) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          drv_word = pending_words.pop_front();
          operation <= drv_word.op;
          x_start <= drv_word.xs;
          y_start <= drv_word.ys;
          x_end <= drv_word.xe;
          y_end <= drv_word.ye;
          color <= drv_word.color;
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  task automatic check_pixel();
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected pixel: x=%0d y=%0d color=%h last=%b", pixel_x, pixel_y,
                 pixel_color, last_pixel);
    end else begin
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (last_pixel) lines_finished++;
      if (pixel_x !== want.x || pixel_y !== want.y || pixel_color !== want.color ||
          last_pixel !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Pixel %0d mismatch: expected x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                   pixels_checked, want.x, want.y, want.color, want.last,
                   pixel_x, pixel_y, pixel_color, last_pixel);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pixel();
      stall_clock++;
      if (stall_clock % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_mode == 0) begin
        stall_next = 1'b0;
      end else if (stall_mode == 1) begin
        stall_next = ($urandom_range(0, 3) == 0);
      end else begin
        if (stall_run > 0) stall_run--;
        else if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 10);
        stall_next = (stall_run > 0);
      end
      out_stall <= stall_next;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words taken and %0d pixels outstanding.",
               cycle_count, words_taken, expected_pixels.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (words_taken < words_total) @(posedge clk);
    while (expected_pixels.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words including %0d line loads; checked %0d pixels across %0d completed lines.",
             words_taken, loads_taken, pixels_checked, lines_finished);
    $display("Mismatched or unexpected pixels: %0d.", mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/blg_pkg.sv
hw/rtl/blg_front.sv
hw/rtl/blg_queue.sv
hw/rtl/blg_back.sv
hw/rtl/bresenham_line_generator_core.sv
tb/bresenham_line_generator_core_tb.sv
